@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ hw/rtl/rali_pkg.sv @@
// Package for the RTP audio level extension inserter: widths, codes and the block table.
package rali_pkg;

	localparam int BYTE_W      = 8;
	localparam int PKT_LEN_W   = 16;
	localparam int PT_W        = 7;
	localparam int EXT_ID_W    = 4;
	localparam int LEVEL_W     = 7;
	localparam int HDR_W       = 7;
	localparam int CC_W        = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 7;
	localparam int IN_TDATA_W  = 24;
	localparam int BLK_LEN     = 8;
	localparam int BLK_IDX_W   = 3;
	localparam int BLK_CNT_W   = 4;

	localparam logic [HDR_W-1:0]  RTP_FIXED_HDR = 7'd12;
	localparam logic [BYTE_W-1:0] RTP_X_BIT     = 8'h10;
	localparam logic [BYTE_W-1:0] EXT_PROFILE_HI = 8'hBE;
	localparam logic [BYTE_W-1:0] EXT_PROFILE_LO = 8'hDE;
	localparam logic [BYTE_W-1:0] EXT_VOICE_BIT  = 8'h80;

	localparam logic [LEVEL_W-1:0]  LEVEL_RESET  = 7'd30;
	localparam logic [EXT_ID_W-1:0] EXT_ID_RESET = 4'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MATCH_PT = 2'd0,
		REG_EXT_ID   = 2'd1,
		REG_LEVEL    = 2'd2
	} cfg_reg_t;

	function automatic logic [BYTE_W-1:0] blk_byte(
		input logic [BLK_IDX_W-1:0] idx,
		input logic [EXT_ID_W-1:0]  ext_id,
		input logic [LEVEL_W-1:0]   level
	);
		logic [BYTE_W-1:0] b;
		unique case (idx)
			3'd0: b = EXT_PROFILE_HI;
			3'd1: b = EXT_PROFILE_LO;
			3'd2: b = 8'h00;
			3'd3: b = 8'h01;
			3'd4: b = {ext_id, 4'h0};
			3'd5: b = EXT_VOICE_BIT | {1'b0, level};
			3'd6: b = 8'h00;
			3'd7: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

@@ hw/rtl/rtp_audio_level_ext_inserter.sv @@
// RTP audio level extension inserter: top level.
//
// Input stream s_axis_*: one packet byte per transaction, tlast on the final
// byte, packet length in tdata and payload type in tuser (both taken on the
// first byte). Output stream m_axis_*: one byte per transaction, tlast on the
// final byte, tuser set on every byte of an extended packet.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high, index 0 = match payload type, 1 = extension ID, 2 = level.
// Each input transaction reaches its output byte in the next cycle, held in
// a single output register. Throughput is one byte per cycle while the
// receiver is ready; after the last header byte of an extended packet the
// input is held off while the extension block (BE DE 00 01, id<<4,
// 80|level, 00 00) drains from the output register.
// A stalled receiver holds the output register, which lowers s_axis_tready in
// the same cycle. Reset empties the output register, returns the parser to
// the start of a packet and loads the register defaults (0, 1, 30).
module rtp_audio_level_ext_inserter
	import rali_pkg::*;
#(
	parameter int LENGTH_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [IN_TDATA_W-1:0]   s_axis_tdata,  // in_byte[7:0], packet_length[23:8]
	input  logic                    s_axis_tlast,
	input  logic [PT_W-1:0]         s_axis_tuser,  // rtp_pt[6:0]
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [BYTE_W-1:0]       m_axis_tdata,  // out_byte[7:0]
	output logic                    m_axis_tlast,
	output logic                    m_axis_tuser,  // extended[0]
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	logic [PT_W-1:0]        match_pt_q;
	logic [EXT_ID_W-1:0]    ext_id_q;
	logic [LEVEL_W-1:0]     level_q;

	logic [LENGTH_BITS-1:0] pos_q;
	logic [HDR_W-1:0]       hdr_q;
	logic                   ins_q;

	logic                   out_valid_q;
	logic [BYTE_W-1:0]      out_byte_q;
	logic                   out_last_q;
	logic                   out_ext_q;
	logic [BLK_CNT_W-1:0]   blk_cnt_q;
	logic                   blk_last_q;

	logic [BYTE_W-1:0]      in_byte;
	logic [PKT_LEN_W-1:0]   in_len;
	logic                   first;
	logic [HDR_W-1:0]       hdr_now;
	logic                   ins_now;
	logic                   block_now;
	logic [BYTE_W-1:0]      ob;
	logic                   advance;
	logic                   in_fire;
	logic                   blk_fire;
	logic [BLK_IDX_W-1:0]   blk_idx;
	logic [HDR_W-1:0]       hdr_first;
	logic                   ins_first;

	assign in_byte = s_axis_tdata[BYTE_W-1:0];
	assign in_len  = s_axis_tdata[BYTE_W +: PKT_LEN_W];
	assign first   = (pos_q == '0);

	assign hdr_first = RTP_FIXED_HDR + {1'b0, in_byte[CC_W-1:0], 2'b00};
	assign ins_first = (match_pt_q != '0) && (s_axis_tuser == match_pt_q) &&
		((in_byte & RTP_X_BIT) == '0) && (in_len >= {{(PKT_LEN_W-HDR_W){1'b0}}, hdr_first});

	assign hdr_now   = first ? hdr_first : hdr_q;
	assign ins_now   = first ? ins_first : ins_q;
	assign block_now = ins_now &&
		(({1'b0, pos_q} + 1'b1) == {{(LENGTH_BITS+1-HDR_W){1'b0}}, hdr_now});
	assign ob        = (first && ins_first) ? (in_byte | RTP_X_BIT) : in_byte;

	assign advance       = !out_valid_q || m_axis_tready;
	assign blk_fire      = advance && (blk_cnt_q != '0);
	assign s_axis_tready = advance && (blk_cnt_q == '0);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign blk_idx       = BLK_IDX_W'(BLK_LEN - int'(blk_cnt_q));

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_pt_q <= '0;
			ext_id_q   <= EXT_ID_RESET;
			level_q    <= LEVEL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MATCH_PT: match_pt_q <= cfg_data[PT_W-1:0];
				REG_EXT_ID:   ext_id_q   <= cfg_data[EXT_ID_W-1:0];
				REG_LEVEL:    level_q    <= cfg_data[LEVEL_W-1:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			hdr_q <= '0;
			ins_q <= 1'b0;
		end else if (in_fire) begin
			hdr_q <= hdr_now;
			if (s_axis_tlast) begin
				pos_q <= '0;
				ins_q <= 1'b0;
			end else begin
				ins_q <= ins_now;
				if (pos_q != '1)
					pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			blk_cnt_q   <= '0;
		end else if (blk_fire) begin
			out_valid_q <= 1'b1;
			blk_cnt_q   <= blk_cnt_q - 1'b1;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
			blk_cnt_q   <= block_now ? BLK_CNT_W'(BLK_LEN) : '0;
		end else if (advance) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (blk_fire) begin
			out_byte_q <= blk_byte(blk_idx, ext_id_q, level_q);
			out_last_q <= blk_last_q && (blk_cnt_q == BLK_CNT_W'(1));
			out_ext_q  <= 1'b1;
		end else if (in_fire) begin
			out_byte_q <= ob;
			out_last_q <= s_axis_tlast && !block_now;
			out_ext_q  <= ins_now;
			blk_last_q <= s_axis_tlast;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_ext_q;

endmodule

@@ hw/rtl/rali_checker.sv @@
// Port-level checker for the RTP audio level extension inserter, with its bind.
`include "assert_macros.svh"

module rali_checker
	import rali_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [BYTE_W-1:0]     m_axis_tdata,
	input logic                  m_axis_tlast,
	input logic                  m_axis_tuser,
	input logic                  cfg_ready
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
	`ASSERT_SAME(a_stall_blocks_in, clk, arst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
	`ASSERT_NEXT(a_in_reaches_out, clk, arst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid)
	`ASSERT_SAME(a_cfg_always_ready, clk, arst_n, 1'b1, cfg_ready)

endmodule

bind rtp_audio_level_ext_inserter rali_checker u_rali_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser),
	.cfg_ready     (cfg_ready)
);
